>>> hdl/ascs_pkg.sv
package ascs_pkg;

    // Block sizing
    localparam int NUM_CHANNELS = 4;
    localparam int RESET_BYTES  = 8;
    localparam int CH_W         = 2;
    localparam int PERIOD_W     = 20;
    localparam int SEL_W        = 5;
    localparam int CODE_W       = 24;
    localparam int UV_W         = 24;

    // Microcode store: reset frame first, scan program after it
    localparam int SCAN_LEN   = 20;
    localparam int PROG_LEN   = RESET_BYTES + SCAN_LEN;
    localparam int PC_W       = $clog2(PROG_LEN);
    localparam int LOOP_W     = $clog2(NUM_CHANNELS);
    localparam int SCAN_ENTRY = RESET_BYTES;
    localparam int CHREG_STEP = SCAN_ENTRY + 14;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd100000;
    localparam logic [3:0]          ENABLE_RST = 4'd0;
    localparam logic [19:0]         POS_RST    = 20'd100384;
    localparam logic [19:0]         NEG_RST    = 20'd744150;

    // Sample scaling: floor(code * 10^7 / (2^24 - 1)) - 5 * 10^6
    localparam logic [CODE_W-1:0] UV_SCALE  = 24'd10000000;
    localparam logic [CODE_W-1:0] CODE_FULL = 24'hFFFFFF;
    localparam logic [UV_W-1:0]   UV_OFFSET = 24'd5000000;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FAIL  = 2'd1,
        PH_COMMS = 2'd2,
        PH_RESET = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CFG_PERIOD = 2'd0,
        CFG_ENABLE = 2'd1,
        CFG_POS    = 2'd2,
        CFG_NEG    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    // Byte source of one microcode step
    typedef enum logic [1:0] {
        SRC_CONST   = 2'd0,
        SRC_CH_ADDR = 2'd1,
        SRC_CH_HI   = 2'd2,
        SRC_CH_LO   = 2'd3
    } t_src;

    typedef struct packed {
        t_src            src;
        logic [7:0]      data;
        logic            frame_end;
        logic            done;
        logic            loop;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic            start;
        logic [PC_W-1:0] entry;
    } t_seq_cmd;

    typedef struct packed {
        logic       valid;
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       last;
    } t_seq_out;

    typedef struct packed {
        logic                   valid;
        logic [CH_W-1:0]        channel;
        logic signed [UV_W-1:0] uv;
    } t_smp_out;

    // Control store contents
    function automatic t_uword prog_word(input logic [PC_W-1:0] a);
        int     off;
        t_uword w;
        begin
            w        = '0;
            w.src    = SRC_CONST;
            w.target = PC_W'(CHREG_STEP);
            off      = int'(a) - RESET_BYTES;
            if (int'(a) < RESET_BYTES) begin
                w.data      = 8'hFF;
                w.frame_end = (int'(a) == RESET_BYTES - 1);
                w.done      = (int'(a) == RESET_BYTES - 1);
            end else begin
                case (off)
                    // interface mode
                    0: w.data = 8'h02;
                    1: w.data = 8'h08;
                    2: begin w.data = 8'h40; w.frame_end = 1'b1; end
                    // data read
                    3: w.data = 8'h44;
                    4, 5, 6: w.data = 8'h00;
                    7: begin w.data = 8'h00; w.frame_end = 1'b1; end
                    // setup
                    8: w.data = 8'h20;
                    9: w.data = 8'h1F;
                    10: begin w.data = 8'h00; w.frame_end = 1'b1; end
                    // filter
                    11: w.data = 8'h28;
                    12: w.data = 8'h0B;
                    13: begin w.data = 8'h14; w.frame_end = 1'b1; end
                    // channel registers, looped once per channel
                    14: begin w.src = SRC_CH_ADDR; w.data = 8'h10; end
                    15: begin w.src = SRC_CH_HI; w.data = 8'h84; end
                    16: begin
                        w.src       = SRC_CH_LO;
                        w.frame_end = 1'b1;
                        w.loop      = 1'b1;
                    end
                    // ADC mode
                    17: w.data = 8'h01;
                    18: w.data = 8'h20;
                    19: begin w.data = 8'h10; w.frame_end = 1'b1; w.done = 1'b1; end
                    default: w.done = 1'b1;
                endcase
            end
            return w;
        end
    endfunction

endpackage

>>> hdl/ascs_useq.sv
module ascs_useq
    import ascs_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_seq_cmd                    i_cmd,
    input  logic                        i_adv,
    input  logic [CH_W-1:0]             i_ch,
    input  logic [3:0][SEL_W-1:0]       i_pos_sel,
    input  logic [3:0][SEL_W-1:0]       i_neg_sel,
    output t_seq_out                    o_seq
);

    logic              r_run;
    logic [PC_W-1:0]   r_pc;
    logic [LOOP_W-1:0] r_loop;
    logic              n_run;
    logic [PC_W-1:0]   n_pc;
    logic [LOOP_W-1:0] n_loop;
    t_uword            uw;
    logic              ch_hit;
    logic              loop_end;
    logic [SEL_W-1:0]  pos_code;
    logic [SEL_W-1:0]  neg_code;
    logic [7:0]        tx_byte;

    // Control word fetch
    assign uw       = prog_word(r_pc);
    assign ch_hit   = (CH_W'(r_loop) == i_ch);
    assign loop_end = (r_loop == LOOP_W'(NUM_CHANNELS - 1));
    assign pos_code = i_pos_sel[i_ch];
    assign neg_code = i_neg_sel[i_ch];

    // Byte datapath
    always_comb begin
        case (uw.src)
            SRC_CONST:   tx_byte = uw.data;
            SRC_CH_ADDR: tx_byte = uw.data | 8'(r_loop);
            SRC_CH_HI:   tx_byte = ch_hit ? (uw.data | {6'b0, pos_code[4:3]}) : 8'h00;
            SRC_CH_LO:   tx_byte = ch_hit ? {pos_code[2:0], neg_code} : 8'h00;
            default:     tx_byte = 8'h00;
        endcase
    end

    assign o_seq.valid     = r_run;
    assign o_seq.tx_byte   = tx_byte;
    assign o_seq.frame_end = uw.frame_end;
    assign o_seq.last      = uw.done;

    // Step counter and conditional jump
    always_comb begin
        n_run  = r_run;
        n_pc   = r_pc;
        n_loop = r_loop;
        if (i_cmd.start) begin
            n_run  = 1'b1;
            n_pc   = i_cmd.entry;
            n_loop = '0;
        end else if (r_run && i_adv) begin
            if (uw.done) begin
                n_run = 1'b0;
            end else if (uw.loop && !loop_end) begin
                n_pc   = uw.target;
                n_loop = r_loop + 1'b1;
            end else begin
                n_pc = r_pc + 1'b1;
                if (uw.loop) begin
                    n_loop = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pc   <= '0;
            r_loop <= '0;
        end else begin
            r_run  <= n_run;
            r_pc   <= n_pc;
            r_loop <= n_loop;
        end
    end

    // The program always ends a frame on its final byte
    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (!uw.done || uw.frame_end))
        else $error("program ends mid-frame");

    // After the final step is taken the sequencer stops
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && i_adv && uw.done && !i_cmd.start) |=> !r_run)
        else $error("sequencer ran past its final step");

endmodule

>>> hdl/ascs_sample.sv
module ascs_sample
    import ascs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CODE_W-1:0] i_code,
    input  logic [CH_W-1:0]   i_ch,
    input  logic              i_adv,
    output t_smp_out          o_smp
);

    logic                     r_valid;
    logic [2*CODE_W-1:0]      r_prod;
    logic [CH_W-1:0]          r_ch;
    logic [CODE_W-1:0]        quot0;
    logic [CODE_W:0]          rem;
    logic [CODE_W-1:0]        quot;

    // Stage 1: code times full-scale microvolts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_start) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= {{CODE_W{1'b0}}, i_code} * {{CODE_W{1'b0}}, UV_SCALE};
            r_ch   <= i_ch;
        end
    end

    // Stage 2: divide by 2^24-1 as shift plus one correction
    assign quot0 = r_prod[2*CODE_W-1:CODE_W];
    assign rem   = {1'b0, r_prod[CODE_W-1:0]} + {1'b0, quot0};
    assign quot  = quot0 + CODE_W'(rem >= {1'b0, CODE_FULL});

    assign o_smp.valid   = r_valid;
    assign o_smp.channel = r_ch;
    assign o_smp.uv      = $signed(quot - UV_OFFSET);

endmodule

>>> hdl/adc_scan_spi_sequencer.sv
// Path: the first byte of a frame passes the sequencer's pc and run registers, then the output
// word register; a sample passes the ascs_sample product register, then the output register.
// Throughput: a scan tick streams 17+3*NUM_CHANNELS bytes (29), the reset frame RESET_BYTES,
// both at one per cycle while the output is not stalled; the input is not ready again until
// the byte stream or sample report has been handed to the output word register.
// Reset: synchronous, active low; clears phase, timer, channel and output valid, loads defaults.
module adc_scan_spi_sequencer
    import ascs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_cmd,
    input  logic                    i_xfer_failed,
    input  logic [7:0]              i_rx_status,
    input  logic [CODE_W-1:0]       i_rx_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_kind,
    output logic [7:0]              o_tx_byte,
    output logic                    o_frame_end,
    output logic                    o_last,
    output logic [CH_W-1:0]         o_sample_channel,
    output logic signed [UV_W-1:0]  o_sample_uv,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [19:0]             i_cfg_data
);

    // Configuration registers
    logic [PERIOD_W-1:0] r_period;
    logic [3:0]          r_enable;
    logic [19:0]         r_pos_sel;
    logic [19:0]         r_neg_sel;

    // Control state
    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_reset_sent;
    logic                n_reset_sent;
    logic [CH_W-1:0]     r_cur_ch;
    logic [CH_W-1:0]     n_cur_ch;
    logic [PERIOD_W-1:0] r_tick;
    logic [PERIOD_W-1:0] n_tick;

    // Output word register
    logic                r_out_valid;
    logic                n_out_valid;
    t_kind               r_kind;
    logic [7:0]          r_tx_byte;
    logic                r_frame_end;
    logic                r_last;
    logic [CH_W-1:0]     r_smp_ch;
    logic signed [UV_W-1:0] r_smp_uv;

    logic                in_acc;
    logic                slot_free;
    logic [PERIOD_W:0]   tick_sum;
    logic                expire;
    logic [CH_W-1:0]     ch_next;
    logic                smp_start;
    t_seq_cmd            seq_cmd;
    t_seq_out            seq;
    t_smp_out            smp;
    logic                load_seq;
    logic                load_smp;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign tick_sum  = {1'b0, r_tick} + 1'b1;
    assign expire    = (tick_sum >= {1'b0, r_period});
    assign ch_next   = (r_cur_ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : r_cur_ch + 1'b1;

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_reset_sent = r_reset_sent;
        n_cur_ch     = r_cur_ch;
        n_tick       = r_tick;
        if (in_acc) begin
            case (r_phase)
                PH_RESET: n_phase = PH_IDLE;
                PH_COMMS: begin
                    if (i_cmd) begin
                        n_phase = i_xfer_failed ? PH_FAIL : PH_IDLE;
                    end
                end
                PH_IDLE, PH_FAIL: begin
                    if (!i_cmd) begin
                        if (!expire) begin
                            n_tick = tick_sum[PERIOD_W-1:0];
                        end else begin
                            n_tick = '0;
                            if (!r_reset_sent) begin
                                n_reset_sent = 1'b1;
                                n_phase      = PH_RESET;
                            end else begin
                                n_cur_ch = ch_next;
                                if (r_enable[ch_next]) begin
                                    n_phase = PH_COMMS;
                                end
                            end
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Outputs of the control state
    always_comb begin
        o_in_ready    = !seq.valid && !smp.valid;
        o_cfg_ready   = 1'b1;
        seq_cmd.start = 1'b0;
        seq_cmd.entry = '0;
        smp_start     = 1'b0;
        if (in_acc) begin
            case (r_phase)
                PH_COMMS: smp_start = i_cmd && !i_xfer_failed && !i_rx_status[7];
                PH_IDLE, PH_FAIL: begin
                    if (!i_cmd && expire) begin
                        if (!r_reset_sent) begin
                            seq_cmd.start = 1'b1;
                        end else begin
                            seq_cmd.start = r_enable[ch_next];
                            seq_cmd.entry = PC_W'(SCAN_ENTRY);
                        end
                    end
                end
                default: smp_start = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_reset_sent <= 1'b0;
            r_cur_ch     <= '0;
            r_tick       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_reset_sent <= n_reset_sent;
            r_cur_ch     <= n_cur_ch;
            r_tick       <= n_tick;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RST;
            r_enable  <= ENABLE_RST;
            r_pos_sel <= POS_RST;
            r_neg_sel <= NEG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PERIOD: r_period  <= i_cfg_data[PERIOD_W-1:0];
                CFG_ENABLE: r_enable  <= i_cfg_data[3:0];
                CFG_POS:    r_pos_sel <= i_cfg_data;
                CFG_NEG:    r_neg_sel <= i_cfg_data;
                default:    r_enable  <= r_enable;
            endcase
        end
    end

    ascs_useq u_useq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (seq_cmd),
        .i_adv     (slot_free),
        .i_ch      (r_cur_ch),
        .i_pos_sel (r_pos_sel),
        .i_neg_sel (r_neg_sel),
        .o_seq     (seq)
    );

    ascs_sample u_sample (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (smp_start),
        .i_code  (i_rx_data),
        .i_ch    (i_rx_status[CH_W-1:0]),
        .i_adv   (slot_free),
        .o_smp   (smp)
    );

    // Output word register
    assign load_seq = seq.valid && slot_free;
    assign load_smp = smp.valid && slot_free && !seq.valid;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_seq || load_smp) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_seq) begin
            r_kind      <= KIND_BYTE;
            r_tx_byte   <= seq.tx_byte;
            r_frame_end <= seq.frame_end;
            r_last      <= seq.last;
            r_smp_ch    <= '0;
            r_smp_uv    <= '0;
        end else if (load_smp) begin
            r_kind      <= KIND_SAMPLE;
            r_tx_byte   <= 8'h00;
            r_frame_end <= 1'b0;
            r_last      <= 1'b1;
            r_smp_ch    <= smp.channel;
            r_smp_uv    <= smp.uv;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_tx_byte        = r_tx_byte;
    assign o_frame_end      = r_frame_end;
    assign o_last           = r_last;
    assign o_sample_channel = r_smp_ch;
    assign o_sample_uv      = r_smp_uv;

    // Byte stream and sample path are never active together
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(seq.valid && smp.valid))
        else $error("byte and sample sources overlap");

    // The reset phase is only entered together with the reset frame
    a_reset_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RESET) |-> r_reset_sent)
        else $error("reset phase without reset frame");

endmodule
